// ----- hw/rtl/fsf_pkg.sv -----
// Shared constants, codes and types of the frame switch forwarder.
`default_nettype none

package fsf_pkg;

    localparam int PORTS       = 8;
    localparam int FRAME_BYTES = 64;

    localparam int BYTE_W  = 8;
    localparam int PORT_W  = 3;
    localparam int MASK_W  = 8;
    localparam int IDX_W   = $clog2(PORTS);
    localparam int AC_W    = $clog2(PORTS + 1);
    localparam int WPOS_W  = $clog2(FRAME_BYTES);
    localparam int BANK_W  = 1;
    localparam int ADDR_W  = BANK_W + WPOS_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    // The descriptor queue holds one entry per frame bank.
    localparam int Q_DEPTH = 2;
    localparam int QP_W    = $clog2(Q_DEPTH);
    localparam int QC_W    = $clog2(Q_DEPTH + 1);

    localparam logic [BYTE_W-1:0] CH_END = 8'h24;
    localparam logic [BYTE_W-1:0] CH_SEP = 8'h7C;
    localparam logic [BYTE_W-1:0] CH_0   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9   = 8'h39;

    localparam logic MODE_ATTACH = 1'b0;
    localparam logic MODE_BYTE   = 1'b1;

    typedef struct packed {
        logic [BANK_W-1:0] bank;
        logic [WPOS_W-1:0] last_idx;
        logic [MASK_W-1:0] mask;
    } t_desc;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_wr;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

`default_nettype wire

// ----- hw/rtl/fsf_if.sv -----
// Valid/ready channel interfaces for the input items and the forwarded bytes.
`default_nettype none

interface fsf_in_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [fsf_pkg::PORT_W-1:0]  in_port;
    logic [fsf_pkg::BYTE_W-1:0]  in_byte;
    logic [fsf_pkg::BYTE_W-1:0]  station_addr;

    modport source (output valid, mode, in_port, in_byte, station_addr, input ready);
    modport sink   (input valid, mode, in_port, in_byte, station_addr, output ready);
endinterface

interface fsf_out_if;
    logic                        valid;
    logic                        ready;
    logic [fsf_pkg::BYTE_W-1:0]  out_byte;
    logic [fsf_pkg::MASK_W-1:0]  port_mask;
    logic                        last;

    modport source (output valid, out_byte, port_mask, last, input ready);
    modport sink   (input valid, out_byte, port_mask, last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/fsf_front.sv -----
// Front end: port table, frame buffer writes, streaming field decode and forwarding decision.
`default_nettype none

module fsf_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    fsf_in_if.sink                  i_in,
    input  wire fsf_pkg::t_q_status i_q,
    output fsf_pkg::t_wr            o_wr,
    output logic                    o_push,
    output fsf_pkg::t_desc          o_desc
);
    import fsf_pkg::*;

    typedef enum logic [5:0] {
        P_SKIP1 = 6'b000001,
        P_SRC   = 6'b000010,
        P_REST1 = 6'b000100,
        P_SKIP2 = 6'b001000,
        P_DST   = 6'b010000,
        P_DONE  = 6'b100000
    } t_pstate;

    logic [BYTE_W-1:0] r_table [PORTS];
    logic [AC_W-1:0]   r_attached;
    logic [WPOS_W-1:0] r_wpos;
    logic [BANK_W-1:0] r_bank;
    t_pstate           r_pstate, n_pstate;
    logic [BYTE_W-1:0] r_src, n_src;
    logic [BYTE_W-1:0] r_dst, n_dst;

    logic              accept;
    logic              is_byte;
    logic              is_end;
    logic              store_byte;
    logic              is_digit;
    logic              is_sep;
    logic [BYTE_W-1:0] digit;
    logic              found;
    logic [MASK_W-1:0] uni_mask;
    logic [MASK_W-1:0] flood_mask;

    // A byte may only be taken while the current bank is not owned by a queued frame.
    assign i_in.ready = !i_q.full;
    assign accept     = i_in.valid && i_in.ready;
    assign is_byte    = accept && (i_in.mode == MODE_BYTE);
    assign is_end     = i_in.in_byte == CH_END;
    assign store_byte = is_byte && (is_end || (r_wpos < WPOS_W'(FRAME_BYTES - 1)));

    assign is_digit = (i_in.in_byte >= CH_0) && (i_in.in_byte <= CH_9);
    assign is_sep   = i_in.in_byte == CH_SEP;
    assign digit    = i_in.in_byte - CH_0;

    // Field decode advances one stored byte at a time. The end mark is neither a
    // digit nor a separator, so the fields are final when it arrives.
    always_comb begin
        n_pstate = r_pstate;
        n_src    = r_src;
        n_dst    = r_dst;
        unique case (r_pstate)
            P_SKIP1: begin
                if (is_digit) begin
                    n_src    = digit;
                    n_pstate = P_SRC;
                end else if (!is_sep) begin
                    n_pstate = P_REST1;
                end
            end
            P_SRC: begin
                if (is_digit) begin
                    n_src = r_src * 8'd10 + digit;
                end else if (is_sep) begin
                    n_pstate = P_SKIP2;
                end else begin
                    n_pstate = P_REST1;
                end
            end
            P_REST1: begin
                if (is_sep) begin
                    n_pstate = P_SKIP2;
                end
            end
            P_SKIP2: begin
                if (is_digit) begin
                    n_dst    = digit;
                    n_pstate = P_DST;
                end else if (!is_sep) begin
                    n_pstate = P_DONE;
                end
            end
            P_DST: begin
                if (is_digit) begin
                    n_dst = r_dst * 8'd10 + digit;
                end else begin
                    n_pstate = P_DONE;
                end
            end
            P_DONE: begin
                n_pstate = P_DONE;
            end
            default: begin
                n_pstate = P_SKIP1;
            end
        endcase
    end

    // First matching table entry wins; otherwise flood to every addressed port but the source.
    always_comb begin
        found      = 1'b0;
        uni_mask   = '0;
        flood_mask = '0;
        for (int i = 0; i < PORTS; i++) begin
            if (!found && (r_table[i] == r_dst)) begin
                found = 1'b1;
                if (i < MASK_W) begin
                    uni_mask = MASK_W'(1) << i;
                end
            end
            if ((i < MASK_W) && (int'(i_in.in_port) != i) && (r_table[i] != '0)) begin
                flood_mask[i] = 1'b1;
            end
        end
    end

    assign o_wr.en   = store_byte;
    assign o_wr.addr = {r_bank, r_wpos};
    assign o_wr.data = i_in.in_byte;

    assign o_push        = is_byte && is_end && (r_src != r_dst);
    assign o_desc.bank     = r_bank;
    assign o_desc.last_idx = r_wpos;
    assign o_desc.mask     = found ? uni_mask : flood_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attached <= '0;
            r_wpos     <= '0;
            r_bank     <= '0;
            r_pstate   <= P_SKIP1;
            r_src      <= '0;
            r_dst      <= '0;
            for (int i = 0; i < PORTS; i++) begin
                r_table[i] <= '0;
            end
        end else begin
            if (accept && (i_in.mode == MODE_ATTACH) && (r_attached < AC_W'(PORTS))) begin
                r_table[r_attached[IDX_W-1:0]] <= i_in.station_addr;
                r_attached <= r_attached + 1'b1;
            end
            if (store_byte) begin
                if (is_end) begin
                    r_wpos   <= '0;
                    r_pstate <= P_SKIP1;
                    r_src    <= '0;
                    r_dst    <= '0;
                end else begin
                    r_wpos   <= r_wpos + 1'b1;
                    r_pstate <= n_pstate;
                    r_src    <= n_src;
                    r_dst    <= n_dst;
                end
            end
            if (o_push) begin
                r_bank <= r_bank + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/fsf_desc_queue.sv -----
// Two-entry queue of frame descriptors between the front end and the replay engine.
`default_nettype none

module fsf_desc_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire fsf_pkg::t_desc  i_desc,
    input  wire logic            i_pop,
    output fsf_pkg::t_desc       o_head,
    output fsf_pkg::t_q_status   o_status
);
    import fsf_pkg::*;

    t_desc           r_entries [Q_DEPTH];
    logic [QP_W-1:0] r_wr_ptr;
    logic [QP_W-1:0] r_rd_ptr;
    logic [QC_W-1:0] r_count;

    assign o_head          = r_entries[r_rd_ptr];
    assign o_status.empty  = r_count == '0;
    assign o_status.full   = r_count == QC_W'(Q_DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QP_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QP_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/fsf_replay.sv -----
// Replay engine: two-bank frame buffer and the registered output stage.
`default_nettype none

module fsf_replay (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire fsf_pkg::t_wr       i_wr,
    input  wire fsf_pkg::t_desc     i_head,
    input  wire fsf_pkg::t_q_status i_q,
    output logic                    o_pop,
    fsf_out_if.source               o_out
);
    import fsf_pkg::*;

    logic [BYTE_W-1:0] r_mem [MEM_DEPTH];

    logic [WPOS_W-1:0] r_rd_pos;
    logic              r_pend;
    logic              r_pend_last;
    logic [MASK_W-1:0] r_pend_mask;
    logic [BYTE_W-1:0] r_rdata;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic [MASK_W-1:0] r_out_mask;
    logic              r_out_last;

    logic out_fire;
    logic slot_free;
    logic issue;
    logic is_last;

    assign out_fire  = r_out_valid && o_out.ready;
    assign slot_free = !r_out_valid || out_fire;
    // One read in flight at a time; it is only issued when the output slot will be empty.
    assign issue     = !i_q.empty && !r_pend && slot_free;
    assign is_last   = r_rd_pos == i_head.last_idx;
    assign o_pop     = issue && is_last;

    assign o_out.valid     = r_out_valid;
    assign o_out.out_byte  = r_out_byte;
    assign o_out.port_mask = r_out_mask;
    assign o_out.last      = r_out_last;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (issue) begin
            r_rdata     <= r_mem[{i_head.bank, r_rd_pos}];
            r_pend_last <= is_last;
            r_pend_mask <= i_head.mask;
        end
        if (r_pend) begin
            r_out_byte <= r_rdata;
            r_out_mask <= r_pend_mask;
            r_out_last <= r_pend_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pos    <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= issue;
            if (issue) begin
                r_rd_pos <= is_last ? '0 : r_rd_pos + 1'b1;
            end
            if (r_pend) begin
                r_out_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/frame_switch_forwarder_core.sv -----
// Top level of the frame switch forwarder.
//
// The input channel carries attach items (mode 0, station_addr goes to the next
// port) and received bytes (mode 1, in_port and in_byte). Bytes of all ports are
// gathered into one frame until '$'; the fields "src|dst" are decoded on the fly.
// At '$' the frame is dropped if src equals dst, otherwise a descriptor with the
// port mask is queued and the frame is replayed on the output channel, one
// transfer per stored byte, with last set on the '$'.
// The frame buffer has two banks, so one frame can be received while the
// previous one is replayed; a third frame waits (input ready low) until a bank
// is released by the replay of the final byte of its frame.
// Attach items and bytes are taken at one per cycle while a bank is free. Replay
// passes each byte through the registered buffer read and then the output
// register, and issues no new read while one is in flight or the output stalls.
// Reset (synchronous, active low) clears the port table, the queue and the
// output stage; buffer contents are not cleared. When the receiver stalls, the
// output holds its byte, the queue fills and input ready drops.
`default_nettype none

module frame_switch_forwarder_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fsf_in_if.sink    i_in,
    fsf_out_if.source o_out
);
    import fsf_pkg::*;

    t_wr       wr;
    t_desc     push_desc;
    t_desc     head;
    t_q_status q_status;
    logic      push;
    logic      pop;

    fsf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_q     (q_status),
        .o_wr    (wr),
        .o_push  (push),
        .o_desc  (push_desc)
    );

    fsf_desc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_desc   (push_desc),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    fsf_replay u_replay (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_head  (head),
        .i_q     (q_status),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/fsf_checker.sv -----
// Port-level checks of the forwarded byte stream, bound to the top level.
`default_nettype none

module fsf_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_out_valid,
    input wire logic                       i_out_ready,
    input wire logic [fsf_pkg::BYTE_W-1:0] i_out_byte,
    input wire logic [fsf_pkg::MASK_W-1:0] i_out_mask,
    input wire logic                       i_out_last
);

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
            && $stable(i_out_mask) && $stable(i_out_last))
        else $error("output changed while stalled");

    // Bytes of one frame all carry the same port mask.
    a_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_out_last) ##1 i_out_valid
            |-> i_out_mask == $past(i_out_mask))
        else $error("port mask changed inside a frame");

    // The replay path never reloads the output in the cycle of a transfer.
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready |=> !i_out_valid)
        else $error("output reloaded in the cycle of a transfer");

endmodule

bind frame_switch_forwarder_core fsf_checker u_fsf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_mask  (o_out.port_mask),
    .i_out_last  (o_out.last)
);

`default_nettype wire
